// ===== src/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: shared constants and helpers for the congestion window tracker
// Field widths, reset values, register indexes, operation and phase codes and the loss threshold rule.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int WIN_W  = 11;
	localparam int ACK_W  = 32;
	localparam int DUP_W  = 4;
	localparam int IDX_W  = 2;
	localparam int OUT_W  = 56;

	localparam logic [WIN_W-1:0] MAX_WINDOW = 11'd1024;

	// reset values of the configuration registers
	localparam logic [WIN_W-1:0] RST_INIT_THRESH = 11'd64;
	localparam logic [WIN_W-1:0] RST_INIT_WINDOW = 11'd1;
	localparam logic [DUP_W-1:0] RST_DUP_LIMIT   = 4'd3;
	localparam logic [WIN_W-1:0] RST_MIN_THRESH  = 11'd2;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_INIT_THRESH = 2'd0;
	localparam logic [IDX_W-1:0] REG_INIT_WINDOW = 2'd1;
	localparam logic [IDX_W-1:0] REG_DUP_LIMIT   = 2'd2;
	localparam logic [IDX_W-1:0] REG_MIN_THRESH  = 2'd3;

	// operation codes
	localparam logic OP_ACK     = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// phase codes
	localparam logic PH_SLOW  = 1'b0;
	localparam logic PH_AVOID = 1'b1;

	typedef logic [WIN_W-1:0] win_t;

	// zero is taken as one
	function automatic win_t at_least_one(input win_t v);
		return (v == '0) ? win_t'(1) : v;
	endfunction

	// threshold after a loss: max(window/2, floor)
	function automatic win_t loss_thresh(input win_t cwnd, input win_t min_thr);
		win_t half;
		win_t flr;
		half = cwnd >> 1;
		flr  = at_least_one(min_thr);
		return (half < flr) ? flr : half;
	endfunction

endpackage

// ===== src/tcp_congestion_window_top.sv =====
// ----------------------------------------------------------------------------
// tcp_congestion_window_top: congestion window tracker for one connection
// Slow start and congestion avoidance, duplicate ACK loss detection.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one command per transaction: s_tuser[0] is the
//   opcode (0 = ACK arrived, 1 = restart from the registers), s_tdata the
//   32-bit ACK number. Every command yields exactly one result on the master
//   stream: window, threshold, phase, loss flag and the acked count.
//   Configuration registers are written through the cfg channel (always
//   ready); the user must do so only while no command is in flight, which
//   the block does not enforce. The result is registered, appearing in the
//   cycle after acceptance. Throughput: one command per cycle unless the
//   receiver stalls; the state update is one compare/increment pass from
//   the state registers into the result register. On a stall the result
//   register holds and s_tready drops only while a result is pending and
//   m_tready is low. Reset: window 1, threshold 64, slow start, no ACK
//   recorded, count 0, registers at 64 / 1 / 3 / 2. No clearing pass.
// ----------------------------------------------------------------------------
module tcp_congestion_window_top
	import tcw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [WIN_W-1:0]  cfg_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [ACK_W-1:0]  s_tdata,   // [31:0] ack_number
	input  logic [0:0]        s_tuser,   // [0] opcode
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata    // [10:0] window, [21:11] threshold,
	                                     // [22] phase, [23] loss_seen,
	                                     // [55:24] acked_count
);

	// configuration
	win_t             init_thresh_q;
	win_t             init_window_q;
	logic [DUP_W-1:0] dup_limit_q;
	win_t             min_thresh_q;

	// connection state
	win_t             cwnd_q;
	win_t             ssthresh_q;
	logic             mode_q;
	win_t             avoid_q;
	logic [ACK_W-1:0] prev_ack_q;
	logic             last_valid_q;
	logic [DUP_W-1:0] dup_q;
	logic [ACK_W-1:0] acked_q;

	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic             accept;
	logic             opcode;
	logic [ACK_W-1:0] ack;

	// next state
	win_t             cwnd_d, ssthresh_d, avoid_d;
	logic             mode_d, last_valid_d, loss_d;
	logic [ACK_W-1:0] prev_ack_d, acked_d;
	logic [DUP_W-1:0] dup_d;

	// intermediate values of the ACK path
	logic [DUP_W-1:0] dup_n;
	logic             loss;
	win_t             c1, t1, a1, c2, c3, a2, a3, iw;
	logic             m1;

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign opcode    = s_tuser[0];
	assign ack       = s_tdata;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	always_comb begin
		// duplicate detection
		if (last_valid_q && prev_ack_q == ack) begin
			dup_n = dup_q + 4'd1;
		end else begin
			dup_n = 4'd1;
		end
		loss = (dup_n == dup_limit_q);

		// slow start stage
		c1 = cwnd_q;
		t1 = ssthresh_q;
		a1 = avoid_q;
		m1 = mode_q;
		c2 = cwnd_q;
		if (mode_q == PH_SLOW) begin
			if (loss) begin
				c1 = win_t'(1);
				t1 = loss_thresh(cwnd_q, min_thresh_q);
				a1 = '0;
			end
			c2 = (c1 < t1 && c1 < MAX_WINDOW) ? c1 + win_t'(1) : c1;
			m1 = (c2 == t1) ? PH_AVOID : PH_SLOW;
		end

		// avoidance stage; a loss is applied again here after a switch
		c3 = c2;
		a2 = a1;
		a3 = a1;
		mode_d = m1;
		ssthresh_d = t1;
		if (m1 == PH_AVOID) begin
			a2 = a1 + win_t'(1);
			if (a2 >= c2) begin
				c3 = (c2 < MAX_WINDOW) ? c2 + win_t'(1) : c2;
				a3 = '0;
			end else begin
				a3 = a2;
			end
			if (loss) begin
				ssthresh_d = loss_thresh(c3, min_thresh_q);
				c3 = win_t'(1);
				a3 = '0;
				mode_d = PH_SLOW;
			end
		end

		iw = at_least_one(init_window_q);
		if (iw > MAX_WINDOW) begin
			iw = MAX_WINDOW;
		end

		if (opcode == OP_RESTART) begin
			cwnd_d       = iw;
			ssthresh_d   = at_least_one(init_thresh_q);
			mode_d       = PH_SLOW;
			avoid_d      = '0;
			last_valid_d = 1'b0;
			prev_ack_d   = '0;
			dup_d        = '0;
			acked_d      = '0;
			loss_d       = 1'b0;
		end else begin
			cwnd_d       = c3;
			avoid_d      = a3;
			last_valid_d = 1'b1;
			prev_ack_d   = ack;
			dup_d        = loss ? '0 : dup_n;
			acked_d      = (acked_q <= ack) ? acked_q + 32'd1 : acked_q;
			loss_d       = loss;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_thresh_q <= RST_INIT_THRESH;
			init_window_q <= RST_INIT_WINDOW;
			dup_limit_q   <= RST_DUP_LIMIT;
			min_thresh_q  <= RST_MIN_THRESH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_INIT_THRESH: init_thresh_q <= cfg_data;
				REG_INIT_WINDOW: init_window_q <= cfg_data;
				REG_DUP_LIMIT:   dup_limit_q   <= cfg_data[DUP_W-1:0];
				REG_MIN_THRESH:  min_thresh_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cwnd_q       <= win_t'(1);
			ssthresh_q   <= RST_INIT_THRESH;
			mode_q       <= PH_SLOW;
			avoid_q      <= '0;
			prev_ack_q   <= '0;
			last_valid_q <= 1'b0;
			dup_q        <= '0;
			acked_q      <= '0;
		end else if (accept) begin
			cwnd_q       <= cwnd_d;
			ssthresh_q   <= ssthresh_d;
			mode_q       <= mode_d;
			avoid_q      <= avoid_d;
			prev_ack_q   <= prev_ack_d;
			last_valid_q <= last_valid_d;
			dup_q        <= dup_d;
			acked_q      <= acked_d;
		end
	end

	// result register: load on a transaction, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {acked_d, loss_d, mode_d, ssthresh_d, cwnd_d};
		end
	end

	a_cwnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		cwnd_q != '0 && cwnd_q <= MAX_WINDOW)
		else $error("congestion window out of range");

	a_slow_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == PH_SLOW |-> avoid_q == '0)
		else $error("avoidance ACK count nonzero in slow start");

	a_avoid_count: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == PH_AVOID |-> avoid_q < cwnd_q)
		else $error("avoidance ACK count reached window");

	a_loss_state: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == OP_ACK && loss |=>
			mode_q == PH_SLOW && dup_q == '0 && cwnd_q <= win_t'(2) && m_tdata[23])
		else $error("loss did not reset window state");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid && m_tdata[10:0] == cwnd_q && m_tdata[55:24] == acked_q)
		else $error("result does not match state");

endmodule

// ===== tb/sv/tcp_congestion_window_check.sv =====
// ----------------------------------------------------------------------------
// tcp_congestion_window_check: result checker for the congestion window tracker
// Watches the register, command and result channels, keeps its own copy of
// the window state, predicts one result per accepted command and compares it
// field by field with what the block returns, in order.
// ----------------------------------------------------------------------------
module tcp_congestion_window_check
	import tcw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [WIN_W-1:0]  cfg_data,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [ACK_W-1:0]  s_tdata,
	input  logic [0:0]        s_tuser,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [OUT_W-1:0]  m_tdata,
	output int                fail_count,
	output int                pending
);

	// laid out so that the lowest member sits in the lowest bits of m_tdata
	typedef struct packed {
		logic [ACK_W-1:0] acked;
		logic             loss;
		logic             phase;
		win_t             threshold;
		win_t             window;
	} cw_result_t;

	cw_result_t expected_results[$];

	// register copies
	win_t             reg_init_thresh;
	win_t             reg_init_window;
	logic [DUP_W-1:0] reg_dup_limit;
	win_t             reg_min_thresh;

	// connection state
	win_t             cwnd;
	win_t             ssthresh;
	logic             phase;
	logic [WIN_W:0]   avoid_cnt;
	logic [ACK_W-1:0] prev_ack;
	logic             prev_ack_seen;
	logic [DUP_W-1:0] dup_cnt;
	logic [ACK_W-1:0] acked_total;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	task automatic report(input string what);
		if (fail_count < 50)
			$display("%0t error: %s", $time, what);
		fail_count++;
	endtask

	function automatic win_t one_if_zero(input win_t v);
		return (v == '0) ? win_t'(1) : v;
	endfunction

	function automatic void take_loss();
		win_t half;
		win_t flr;
		half = cwnd >> 1;
		flr = one_if_zero(reg_min_thresh);
		ssthresh = (half < flr) ? flr : half;
		cwnd = win_t'(1);
		avoid_cnt = '0;
	endfunction

	function automatic void bump_window();
		if (cwnd < MAX_WINDOW)
			cwnd = cwnd + win_t'(1);
	endfunction

	// advance the connection state by one command and return the new window report
	function automatic cw_result_t advance_window(input logic op, input logic [ACK_W-1:0] ack);
		cw_result_t res;
		logic loss;
		win_t w;
		loss = 1'b0;
		if (op == OP_RESTART) begin
			w = one_if_zero(reg_init_window);
			cwnd = (w > MAX_WINDOW) ? MAX_WINDOW : w;
			ssthresh = one_if_zero(reg_init_thresh);
			phase = PH_SLOW;
			avoid_cnt = '0;
			prev_ack_seen = 1'b0;
			prev_ack = '0;
			dup_cnt = '0;
			acked_total = '0;
		end else begin
			if (prev_ack_seen && prev_ack == ack) begin
				dup_cnt = dup_cnt + 4'd1;
			end else begin
				prev_ack = ack;
				prev_ack_seen = 1'b1;
				dup_cnt = 4'd1;
			end
			if (dup_cnt == reg_dup_limit) begin
				dup_cnt = '0;
				loss = 1'b1;
			end
			if (phase == PH_SLOW) begin
				if (loss)
					take_loss();
				if (cwnd < ssthresh)
					bump_window();
				if (cwnd == ssthresh)
					phase = PH_AVOID;
			end
			// a loss that just pushed slow start into avoidance is applied once more here
			if (phase == PH_AVOID) begin
				avoid_cnt = avoid_cnt + (WIN_W+1)'(1);
				if (avoid_cnt >= cwnd) begin
					bump_window();
					avoid_cnt = '0;
				end
				if (loss) begin
					take_loss();
					phase = PH_SLOW;
				end
			end
			if (acked_total <= ack)
				acked_total = acked_total + 32'd1;
		end
		res.window = cwnd;
		res.threshold = ssthresh;
		res.phase = phase;
		res.loss = loss;
		res.acked = acked_total;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		cw_result_t got;
		cw_result_t want;
		if (!arst_n) begin
			reg_init_thresh = RST_INIT_THRESH;
			reg_init_window = RST_INIT_WINDOW;
			reg_dup_limit = RST_DUP_LIMIT;
			reg_min_thresh = RST_MIN_THRESH;
			cwnd = win_t'(1);
			ssthresh = win_t'(64);
			phase = PH_SLOW;
			avoid_cnt = '0;
			prev_ack = '0;
			prev_ack_seen = 1'b0;
			dup_cnt = '0;
			acked_total = '0;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_INIT_THRESH: reg_init_thresh = cfg_data;
					REG_INIT_WINDOW: reg_init_window = cfg_data;
					REG_DUP_LIMIT:   reg_dup_limit = cfg_data[DUP_W-1:0];
					REG_MIN_THRESH:  reg_min_thresh = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_results.size() == 0) begin
					report("result transaction with no command outstanding");
				end else begin
					want = expected_results.pop_front();
					if (got.window !== want.window)
						report($sformatf("window got %0d want %0d", got.window, want.window));
					if (got.threshold !== want.threshold)
						report($sformatf("threshold got %0d want %0d",
							got.threshold, want.threshold));
					if (got.phase !== want.phase)
						report($sformatf("phase got %0b want %0b", got.phase, want.phase));
					if (got.loss !== want.loss)
						report($sformatf("loss_seen got %0b want %0b", got.loss, want.loss));
					if (got.acked !== want.acked)
						report($sformatf("acked_count got %0d want %0d", got.acked, want.acked));
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(advance_window(s_tuser[0], s_tdata));
			pending <= expected_results.size();
		end
	end

endmodule

// ===== tb/sv/tcp_congestion_window_top_test.sv =====
// ----------------------------------------------------------------------------
// tcp_congestion_window_top_test: stimulus and verdict for the window tracker
// Drives directed corner cases (double loss, wrapping repeat count, register
// values out of range, saturation) and then phases of random ACK streams under
// random register settings, with random source gaps and sink stalls in all but the last.
// ----------------------------------------------------------------------------
module tcp_congestion_window_top_test;
	import tcw_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [WIN_W-1:0]  cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [ACK_W-1:0]  s_tdata = '0;
	logic [0:0]        s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b1;
	logic [OUT_W-1:0]  m_tdata;

	int fail_count;
	int pending;
	int src_gap_pct = 0;
	int sink_stall_pct = 0;
	int stall_left = 0;
	logic quiet = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	tcp_congestion_window_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	tcp_congestion_window_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// sink: stall in bursts of random length
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 99) < sink_stall_pct) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 8);
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

	task automatic send_cmd(input logic op, input logic [ACK_W-1:0] ack);
		if (!quiet && $urandom_range(0, 99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= ack;
		do @(posedge clk); while (!s_tready);
	endtask

	// drop valid and hold until every outstanding result has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WIN_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_regs(input logic [WIN_W-1:0] thr, input logic [WIN_W-1:0] win,
			input logic [WIN_W-1:0] lim, input logic [WIN_W-1:0] min_thr);
		write_reg(REG_INIT_THRESH, thr);
		write_reg(REG_INIT_WINDOW, win);
		write_reg(REG_DUP_LIMIT, lim);
		write_reg(REG_MIN_THRESH, min_thr);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [WIN_W-1:0] pick_size(input int hi);
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0:       return '0;
			1:       return '1;
			2:       return MAX_WINDOW;
			3:       return WIN_W'($urandom_range(0, 2047));
			default: return WIN_W'($urandom_range(1, hi));
		endcase
	endfunction

	// mostly rising ACK numbers with bursts of repeats, some noise and restarts
	task automatic run_traffic(input int n);
		int sent;
		int burst;
		int r;
		logic [ACK_W-1:0] last_no;
		logic [ACK_W-1:0] next_no;
		sent = 0;
		last_no = $urandom;
		next_no = $urandom_range(0, 50);
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 2) begin
				send_cmd(OP_RESTART, $urandom);
				sent++;
			end else if (r < 22) begin
				burst = $urandom_range(1, 16);
				repeat (burst) send_cmd(OP_ACK, last_no);
				sent += burst;
			end else begin
				if (r < 82) begin
					next_no = next_no + $urandom_range(1, 1460);
					last_no = next_no;
				end else if (r < 92) begin
					last_no = $urandom;
				end else begin
					last_no = $urandom_range(0, 15);
				end
				send_cmd(OP_ACK, last_no);
				sent++;
			end
		end
	endtask

	initial begin
		int ph;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: the third arrival of the first ACK loses twice in one step
		send_cmd(OP_ACK, 32'h0000_0000);
		send_cmd(OP_ACK, 32'h0000_0000);
		send_cmd(OP_ACK, 32'h0000_0000);
		send_cmd(OP_ACK, 32'hFFFF_FFFF);
		send_cmd(OP_ACK, 32'h8000_0000);
		send_cmd(OP_ACK, 32'h0000_0005);
		settle();

		// oversized window saturates, zero limit flags loss on the 16th arrival
		program_regs('1, '1, 11'd0, 11'd0);
		send_cmd(OP_RESTART, 32'h5555_AAAA);
		repeat (16) send_cmd(OP_ACK, 32'hFFFF_FFFF);
		settle();

		// zero registers taken as one, limit of one flags every new number
		program_regs(11'd0, 11'd0, 11'd1, MAX_WINDOW);
		send_cmd(OP_RESTART, 32'h0);
		send_cmd(OP_ACK, 32'h1);
		send_cmd(OP_ACK, 32'h2);
		settle();

		// window above the threshold in slow start
		program_regs(11'd1, MAX_WINDOW, 11'd15, 11'd1);
		send_cmd(OP_RESTART, 32'h0);
		send_cmd(OP_ACK, 32'h7);

		for (ph = 0; ph < 6; ph++) begin
			settle();
			src_gap_pct = (ph == 5) ? 0 : $urandom_range(0, 2) * 20;
			sink_stall_pct <= (ph == 5) ? 0 : $urandom_range(0, 2) * 20;
			quiet <= (ph == 5);
			program_regs(pick_size(48), pick_size(12),
				WIN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
					: $urandom_range(2, 5)),
				pick_size(8));
			send_cmd(OP_RESTART, $urandom);
			run_traffic(108);
		end

		settle();
		repeat (3) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
src/tcw_pkg.sv
src/tcp_congestion_window_top.sv
tb/sv/tcp_congestion_window_check.sv
tb/sv/tcp_congestion_window_top_test.sv
